### src/nfa_pkg.sv
package nfa_pkg;

  localparam int NUM_STATES      = 16;
  localparam int MAX_TRANSITIONS = 64;
  localparam int SYMBOL_BITS     = 8;

  localparam int FUNC_W       = 2;
  localparam int STATE_FIELD_W = 4;
  localparam int SYMBOL_FIELD_W = 8;
  localparam int INIT_COUNT_W = 5;
  localparam int ACCEPT_W     = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam int SYM_W   = (SYMBOL_BITS < SYMBOL_FIELD_W) ? SYMBOL_BITS : SYMBOL_FIELD_W;
  localparam int CNT_W   = $clog2(MAX_TRANSITIONS + 1);
  localparam int MASKX_W = (NUM_STATES > ACCEPT_W) ? NUM_STATES : ACCEPT_W;

  localparam logic [NUM_STATES-1:0] STATE_ONE = NUM_STATES'(1);

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SYMBOL = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_EMPTY  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK   = 1'd1;

  typedef struct packed {
    logic [STATE_FIELD_W-1:0] src;
    logic [STATE_FIELD_W-1:0] dst;
    logic [SYM_W-1:0]         sym;
  } trans_t;

  typedef struct packed {
    logic we;
    logic live;
  } cell_ctrl_t;

endpackage

### src/nfa_string_acceptor.sv
// NFA string acceptor. Load transitions with add items (clear empties the table), then feed
// a string one symbol item at a time; the final symbol, or an empty-string item, yields one
// result with out_valid high for a single cycle. The receiver cannot stall: sample the result
// ports in that cycle. Clear, add and empty-string items never raise busy. A symbol item keeps
// busy high, and start is ignored, while its partial successor set ripples through a chain of
// MAX_TRANSITIONS cells, one table entry per cell and one cell per cycle. A result appears the
// cycle after its item's work ends.
module nfa_string_acceptor
  import nfa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic [STATE_FIELD_W-1:0]  in_from_state,
  input  logic [STATE_FIELD_W-1:0]  in_to_state,
  input  logic [SYMBOL_FIELD_W-1:0] in_symbol,
  input  logic                      in_last_symbol,
  output logic                      out_valid,
  output logic                      out_accepted,
  output logic                      out_table_overflowed,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      entry_count_r;
  logic                  overflow_r;
  logic                  in_string_r;
  logic [NUM_STATES-1:0] active_r;
  logic [NUM_STATES-1:0] walk_set_r;
  logic [SYM_W-1:0]      walk_sym_r;
  logic                  last_r;
  logic [INIT_COUNT_W-1:0] init_count_r;
  logic [ACCEPT_W-1:0]   accept_mask_r;
  logic                  out_valid_r;
  logic                  out_accepted_r;
  logic                  out_overflow_r;

  logic                  take;
  logic                  do_add;
  logic [NUM_STATES-1:0] init_set;
  logic [MASKX_W-1:0]    accept_wide;
  logic [NUM_STATES-1:0] accept_vec;
  logic [NUM_STATES-1:0] chain_out;
  trans_t                wr_entry;

  logic [NUM_STATES-1:0] link [MAX_TRANSITIONS+1];

  assign take      = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign do_add    = take && (in_func == FUNC_ADD) &&
                     (entry_count_r < CNT_W'(MAX_TRANSITIONS));

  always_comb begin
    for (int s = 0; s < NUM_STATES; s++) begin
      init_set[s] = (s < int'(init_count_r));
    end
    accept_wide = MASKX_W'(accept_mask_r);
    accept_vec  = accept_wide[NUM_STATES-1:0];
    wr_entry.src = in_from_state;
    wr_entry.dst = in_to_state;
    wr_entry.sym = in_symbol[SYM_W-1:0];
  end

  assign link[0] = '0;

  for (genvar i = 0; i < MAX_TRANSITIONS; i++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.we   = do_add && (entry_count_r == CNT_W'(i));
    assign ctrl.live = (CNT_W'(i) < entry_count_r);
    nfa_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .wr_entry (wr_entry),
      .walk_set (walk_set_r),
      .walk_sym (walk_sym_r),
      .acc_in   (link[i]),
      .acc_out  (link[i+1])
    );
  end

  assign chain_out = link[MAX_TRANSITIONS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      entry_count_r  <= '0;
      overflow_r     <= 1'b0;
      in_string_r    <= 1'b0;
      active_r       <= '0;
      init_count_r   <= INIT_COUNT_W'(1);
      accept_mask_r  <= '0;
      out_valid_r    <= 1'b0;
      out_accepted_r <= 1'b0;
      out_overflow_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INITIAL_COUNT: init_count_r  <= cfg_data[INIT_COUNT_W-1:0];
          CFG_ACCEPT_MASK:   accept_mask_r <= cfg_data[ACCEPT_W-1:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (take) begin
            case (in_func)
              FUNC_CLEAR: entry_count_r <= '0;
              FUNC_ADD: begin
                if (do_add) begin
                  entry_count_r <= entry_count_r + CNT_W'(1);
                end else begin
                  overflow_r <= 1'b1;
                end
              end
              FUNC_SYMBOL: begin
                walk_set_r  <= in_string_r ? active_r : init_set;
                walk_sym_r  <= in_symbol[SYM_W-1:0];
                last_r      <= in_last_symbol;
                in_string_r <= 1'b1;
                cnt_r       <= '0;
                state_r     <= ST_WALK;
              end
              FUNC_EMPTY: begin
                active_r       <= init_set;
                out_valid_r    <= 1'b1;
                out_accepted_r <= |(init_set & accept_vec);
                out_overflow_r <= overflow_r;
                overflow_r     <= 1'b0;
                in_string_r    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (cnt_r == CNT_W'(MAX_TRANSITIONS)) begin
            active_r <= chain_out;
            state_r  <= ST_IDLE;
            if (last_r) begin
              out_valid_r    <= 1'b1;
              out_accepted_r <= |(chain_out & accept_vec);
              out_overflow_r <= overflow_r;
              overflow_r     <= 1'b0;
              in_string_r    <= 1'b0;
            end
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = out_accepted_r;
  assign out_table_overflowed = out_overflow_r;

  a_result_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a walk is running");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(MAX_TRANSITIONS))
    else $error("entry count past table capacity");

  a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (cnt_r <= CNT_W'(MAX_TRANSITIONS)))
    else $error("walk counter overran the chain");

  a_walk_table_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |=> $stable(entry_count_r))
    else $error("table changed during a walk");

endmodule

### src/nfa_cell.sv
module nfa_cell
  import nfa_pkg::*;
(
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  trans_t                wr_entry,
  input  logic [NUM_STATES-1:0] walk_set,
  input  logic [SYM_W-1:0]      walk_sym,
  input  logic [NUM_STATES-1:0] acc_in,
  output logic [NUM_STATES-1:0] acc_out
);

  trans_t                entry_r;
  logic [NUM_STATES-1:0] acc_r;
  logic [NUM_STATES-1:0] src_hot;
  logic [NUM_STATES-1:0] dst_hot;
  logic                  hit;
  logic [NUM_STATES-1:0] acc_nxt;

  always_comb begin
    src_hot = STATE_ONE << entry_r.src;
    dst_hot = STATE_ONE << entry_r.dst;
    hit     = ctrl.live && (entry_r.sym == walk_sym) && (|(walk_set & src_hot));
    acc_nxt = hit ? (acc_in | dst_hot) : acc_in;
  end

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      entry_r <= wr_entry;
    end
    acc_r <= acc_nxt;
  end

  assign acc_out = acc_r;

endmodule
